// File: hw/rtl/dnth_pkg.sv
// Package for the dentry name TEA hash block: constants and the structs that
// pass between the byte gatherer, the round cells and the top level.
// No dependencies.
`timescale 1ns / 1ps

package dnth_pkg;

   localparam logic [31:0] INIT_WORD0 = 32'h6745_2301;
   localparam logic [31:0] INIT_WORD1 = 32'hefcd_ab89;
   localparam logic [31:0] TEA_DELTA  = 32'h9e37_79b9;
   localparam logic [7:0]  DOT_CHAR   = 8'h2e;

   // A finished 16-byte chunk as seen at the byte that completes it.
   typedef struct packed {
      logic             complete;
      logic             final_chunk;
      logic             dot_name;
      logic [3:0][31:0] words;
   } chunk_type;

   // One slot of the round chain.
   typedef struct packed {
      logic             valid;
      logic             final_chunk;
      logic             dot_name;
      logic [31:0]      x;
      logic [31:0]      y;
      logic [31:0]      r0;
      logic [31:0]      r1;
      logic [3:0][31:0] words;
   } stage_type;

endpackage

// File: hw/rtl/dnth_gather.sv
// Byte gatherer: packs name bytes into four chunk words, tracks the byte
// position and the dot flags, and forms the padded chunk. Uses dnth_pkg.
`timescale 1ns / 1ps

module dnth_gather #(
   parameter int MAX_NAME_BYTES = 255
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          name_byte,
   input  logic [7:0]          name_length,
   input  logic                last_byte,
   output dnth_pkg::chunk_type chunk
);
   import dnth_pkg::*;

   localparam int PW = $clog2(MAX_NAME_BYTES + 1);

   logic [PW-1:0]    pos_ff, pos_in;
   logic [1:0]       dot_ff, dot_in;
   logic [3:0][31:0] words_ff, words_in;
   logic [3:0]       pic;
   logic [4:0]       fill;
   logic [PW-1:0]    start_pos;
   logic [7:0]       pad_byte;
   logic [31:0]      pad_word;
   logic             final_chunk;
   logic [4:0]       k;

   assign pic       = pos_ff[3:0];
   assign fill      = {1'b0, pic} + 5'd1;
   assign start_pos = {pos_ff[PW-1:4], 4'b0000};
   assign pad_byte  = name_length - 8'(start_pos);
   assign pad_word  = {4{pad_byte}};

   // The byte at the size limit ends the name whatever its mark says.
   assign final_chunk = last_byte || (pos_ff == PW'(MAX_NAME_BYTES - 1));

   // Shift the current byte into its word and update the dot flags.
   always_comb begin
      words_in = words_ff;
      words_in[pic[3:2]] = {words_ff[pic[3:2]][23:0], name_byte};
      dot_in = dot_ff;
      if (pos_ff == '0) begin
         dot_in = {1'b0, name_byte == DOT_CHAR};
      end else if (pos_ff == PW'(1) && name_byte == DOT_CHAR) begin
         dot_in[1] = 1'b1;
      end
   end

   // Pad the chunk: words past the name are the pad word, a partial word
   // carries pad bytes above its name bytes.
   always_comb begin
      chunk.complete    = (pic == 4'd15) || final_chunk;
      chunk.final_chunk = final_chunk;
      chunk.dot_name    = ((name_length == 8'd1) && dot_in[0]) ||
                          ((name_length == 8'd2) && (dot_in == 2'b11));
      for (int i = 0; i < 4; i++) begin
         k = (fill > 5'(4 * i)) ? fill - 5'(4 * i) : 5'd0;
         if (k >= 5'd4) begin
            chunk.words[i] = words_in[i];
         end else begin
            case (k[1:0])
               2'd1:    chunk.words[i] = {pad_word[23:0], words_in[i][7:0]};
               2'd2:    chunk.words[i] = {pad_word[15:0], words_in[i][15:0]};
               2'd3:    chunk.words[i] = {pad_word[7:0], words_in[i][23:0]};
               default: chunk.words[i] = pad_word;
            endcase
         end
      end
   end

   assign pos_in = final_chunk ? '0 : pos_ff + 1'b1;

   // Position and flags restart after each name; words clear after a chunk.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         dot_ff   <= '0;
         words_ff <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         dot_ff   <= final_chunk ? 2'b00 : dot_in;
         words_ff <= chunk.complete ? '0 : words_in;
      end
   end

endmodule

// File: hw/rtl/dnth_tea_cell.sv
// One TEA round cell of the round chain; registers its result for the next
// cell. Uses dnth_pkg.
`timescale 1ns / 1ps

module dnth_tea_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  dnth_pkg::stage_type stage_in,
   output dnth_pkg::stage_type stage_out
);
   import dnth_pkg::*;

   localparam logic [63:0] SUM_WIDE = 64'(TEA_DELTA) * 64'(CELL_INDEX + 1);
   localparam logic [31:0] ROUND_SUM = SUM_WIDE[31:0];

   logic [31:0] x_in, y_in;
   stage_type   stage_ff;

   // One round: x first, then y from the new x.
   always_comb begin
      x_in = stage_in.x + (((stage_in.y << 4) + stage_in.words[0]) ^
                           (stage_in.y + ROUND_SUM) ^
                           ((stage_in.y >> 5) + stage_in.words[1]));
      y_in = stage_in.y + (((x_in << 4) + stage_in.words[2]) ^
                           (x_in + ROUND_SUM) ^
                           ((x_in >> 5) + stage_in.words[3]));
   end

   // Payload moves with the chain; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.final_chunk <= stage_in.final_chunk;
         stage_ff.dot_name    <= stage_in.dot_name;
         stage_ff.x           <= x_in;
         stage_ff.y           <= y_in;
         stage_ff.r0          <= stage_in.r0;
         stage_ff.r1          <= stage_in.r1;
         stage_ff.words       <= stage_in.words;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: hw/rtl/dentry_name_tea_hash.sv
// Top level of the dentry name TEA hash: byte gatherer, a chain of
// TEA_ROUNDS round cells and the result register. Uses dnth_pkg,
// dnth_gather and dnth_tea_cell.
//
//   channel | direction | word
//   req_    | in        | name_byte, name_length, last_byte
//   rsp_    | out       | hash_value (one word per name)
//
// One name byte is taken per cycle while req_stall is low. A chunk enters
// the cell chain at its last byte and its running words are written back
// when it leaves the last round cell, so the next chunk of the same name
// cannot enter before that write-back: its last byte stalls while the
// write-back is pending. The hash word is registered in the result register
// when the final chunk leaves the last round cell.
// Reset is synchronous; it clears the valid bits and the name state and loads
// the initial running words. A stalled result freezes the chain once the next
// final chunk reaches its end; bytes that do not end a chunk are still taken.
`timescale 1ns / 1ps

module dentry_name_tea_hash #(
   parameter int MAX_NAME_BYTES = 255,
   parameter int TEA_ROUNDS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_name_byte,
   input  logic [7:0]  req_name_length,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);
   import dnth_pkg::*;

   chunk_type   chunk;
   stage_type   chain [TEA_ROUNDS + 1];
   stage_type   tail;
   logic        advance, accept, inject;
   logic        pending_ff;
   logic [31:0] run0_ff, run1_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_hash_ff;

   dnth_gather #(
      .MAX_NAME_BYTES(MAX_NAME_BYTES)
   ) u_gather (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .name_byte   (req_name_byte),
      .name_length (req_name_length),
      .last_byte   (req_last_byte),
      .chunk       (chunk)
   );

   // The chain stops only when a final result cannot leave.
   assign tail    = chain[TEA_ROUNDS];
   assign advance = !(tail.valid && tail.final_chunk && rsp_valid_ff && rsp_stall);

   // A chunk may enter only when the chain moves and its running words are home.
   assign req_stall = chunk.complete && (!advance || pending_ff);
   assign accept    = req_valid && !req_stall;
   assign inject    = accept && chunk.complete;

   // Head of the chain.
   always_comb begin
      chain[0].valid       = inject;
      chain[0].final_chunk = chunk.final_chunk;
      chain[0].dot_name    = chunk.dot_name;
      chain[0].x           = run0_ff;
      chain[0].y           = run1_ff;
      chain[0].r0          = run0_ff;
      chain[0].r1          = run1_ff;
      chain[0].words       = chunk.words;
   end

   for (genvar g = 0; g < TEA_ROUNDS; g++) begin : g_cell
      dnth_tea_cell #(
         .CELL_INDEX(g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[g]),
         .stage_out (chain[g + 1])
      );
   end

   // Running words: reload for the next name when a final chunk enters,
   // fold in the chain result when an inner chunk leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         run0_ff    <= INIT_WORD0;
         run1_ff    <= INIT_WORD1;
         pending_ff <= 1'b0;
      end else if (inject && chunk.final_chunk) begin
         run0_ff <= INIT_WORD0;
         run1_ff <= INIT_WORD1;
      end else if (inject) begin
         pending_ff <= 1'b1;
      end else if (advance && tail.valid && !tail.final_chunk) begin
         run0_ff    <= tail.r0 + tail.x;
         run1_ff    <= tail.r1 + tail.y;
         pending_ff <= 1'b0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && tail.valid && tail.final_chunk) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tail.valid && tail.final_chunk) begin
         rsp_hash_ff <= tail.dot_name ? 32'd0 : tail.r0 + tail.x;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule
